[hw/rtl/dpbp_pkg.sv]
// Shared types, register codes, reset values and width helpers for the
// depth pixel back-projection block. Depends on nothing; every other file but dpbp_fifo uses it.
`default_nettype none

package dpbp_pkg;

	// Channel payload widths fixed by the pixel and point formats.
	localparam int DEPTH_W = 16;
	localparam int COLOR_W = 8;
	localparam int INV_W   = 24;
	localparam int CTR_W   = 16;
	localparam int XY_W    = 32;
	localparam int WIDTH_W = 13;

	// Configuration channel widths.
	localparam int IDX_W  = 3;
	localparam int DATA_W = 24;

	// Register indexes on the configuration channel.
	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_WIDTH = 3'd0,
		REG_CENTER_X    = 3'd1,
		REG_CENTER_Y    = 3'd2,
		REG_INV_FOCAL_X = 3'd3,
		REG_INV_FOCAL_Y = 3'd4,
		REG_DEPTH_LIMIT = 3'd5,
		REG_DECIMATE    = 3'd6
	} reg_idx_t;

	// All configuration registers as seen by the datapath.
	typedef struct packed {
		logic [WIDTH_W-1:0] image_width;
		logic [CTR_W-1:0]   center_x;
		logic [CTR_W-1:0]   center_y;
		logic [INV_W-1:0]   inv_focal_x;
		logic [INV_W-1:0]   inv_focal_y;
		logic [DEPTH_W-1:0] depth_limit;
		logic               decimate;
	} cfg_t;

	// Reset values of the registers.
	localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH = 13'd640;
	localparam logic [CTR_W-1:0]   RST_CENTER_X    = 16'd5128;
	localparam logic [CTR_W-1:0]   RST_CENTER_Y    = 16'd3848;
	localparam logic [INV_W-1:0]   RST_INV_FOCAL_X = 24'd30270;
	localparam logic [INV_W-1:0]   RST_INV_FOCAL_Y = 24'd30270;
	localparam logic [DEPTH_W-1:0] RST_DEPTH_LIMIT = 16'd1000;
	localparam logic               RST_DECIMATE    = 1'b0;

	// Width of an offset magnitude |pos*16 - center| for a given counter width.
	function automatic int mag_width(input int coord_bits);
		return (coord_bits + 4 > CTR_W) ? coord_bits + 4 : CTR_W;
	endfunction

	// Width of one queue entry: valid flag, two signs, two magnitudes,
	// depth and three colors.
	function automatic int entry_width(input int coord_bits);
		return 3 + 2 * mag_width(coord_bits) + DEPTH_W + 3 * COLOR_W;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/dpbp_ifs.sv]
// Handshake interfaces for the pixel input, point output and configuration
// channels. Depends on dpbp_pkg for the payload widths.
`default_nettype none

// Pixel input channel: one raster pixel per item.
interface dpbp_pixel_if;
	logic                            valid;
	logic                            ready;
	logic [dpbp_pkg::DEPTH_W-1:0]    depth_mm;
	logic [dpbp_pkg::COLOR_W-1:0]    blue;
	logic [dpbp_pkg::COLOR_W-1:0]    green;
	logic [dpbp_pkg::COLOR_W-1:0]    red;
	logic                            start_of_frame;

	modport source (output valid, depth_mm, blue, green, red, start_of_frame, input ready);
	modport sink   (input valid, depth_mm, blue, green, red, start_of_frame, output ready);
endinterface

// Point output channel: one back-projected point per item.
interface dpbp_point_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 point_valid;
	logic signed [dpbp_pkg::XY_W-1:0]     x_pos;
	logic signed [dpbp_pkg::XY_W-1:0]     y_pos;
	logic [dpbp_pkg::DEPTH_W-1:0]         z_pos;
	logic [dpbp_pkg::COLOR_W-1:0]         blue_out;
	logic [dpbp_pkg::COLOR_W-1:0]         green_out;
	logic [dpbp_pkg::COLOR_W-1:0]         red_out;

	modport source (output valid, point_valid, x_pos, y_pos, z_pos, blue_out, green_out,
		red_out, input ready);
	modport sink   (input valid, point_valid, x_pos, y_pos, z_pos, blue_out, green_out,
		red_out, output ready);
endinterface

// Configuration write channel: register index and data.
interface dpbp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [dpbp_pkg::IDX_W-1:0]    index;
	logic [dpbp_pkg::DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/dpbp_regs.sv]
// Configuration register file written through the configuration channel.
// Depends on dpbp_pkg and dpbp_cfg_if.
`default_nettype none

module dpbp_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	dpbp_cfg_if.sink          cfg,
	output dpbp_pkg::cfg_t    regs
);

	dpbp_pkg::cfg_t regs_q;

	// Writes are always taken; an unknown index changes nothing.
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.image_width <= dpbp_pkg::RST_IMAGE_WIDTH;
			regs_q.center_x    <= dpbp_pkg::RST_CENTER_X;
			regs_q.center_y    <= dpbp_pkg::RST_CENTER_Y;
			regs_q.inv_focal_x <= dpbp_pkg::RST_INV_FOCAL_X;
			regs_q.inv_focal_y <= dpbp_pkg::RST_INV_FOCAL_Y;
			regs_q.depth_limit <= dpbp_pkg::RST_DEPTH_LIMIT;
			regs_q.decimate    <= dpbp_pkg::RST_DECIMATE;
		end else if (cfg.valid) begin
			case (dpbp_pkg::reg_idx_t'(cfg.index))
				dpbp_pkg::REG_IMAGE_WIDTH: begin
					regs_q.image_width <= cfg.data[dpbp_pkg::WIDTH_W-1:0];
				end
				dpbp_pkg::REG_CENTER_X: begin
					regs_q.center_x <= cfg.data[dpbp_pkg::CTR_W-1:0];
				end
				dpbp_pkg::REG_CENTER_Y: begin
					regs_q.center_y <= cfg.data[dpbp_pkg::CTR_W-1:0];
				end
				dpbp_pkg::REG_INV_FOCAL_X: begin
					regs_q.inv_focal_x <= cfg.data[dpbp_pkg::INV_W-1:0];
				end
				dpbp_pkg::REG_INV_FOCAL_Y: begin
					regs_q.inv_focal_y <= cfg.data[dpbp_pkg::INV_W-1:0];
				end
				dpbp_pkg::REG_DEPTH_LIMIT: begin
					regs_q.depth_limit <= cfg.data[dpbp_pkg::DEPTH_W-1:0];
				end
				dpbp_pkg::REG_DECIMATE: begin
					regs_q.decimate <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/dpbp_front.sv]
// Front end: accepts pixels, tracks column and row, classifies each pixel as
// dropped, invalid or valid and pushes offset magnitudes into the queue.
// Depends on dpbp_pkg and dpbp_pixel_if.
`default_nettype none

module dpbp_front #(
	parameter  int COORD_BITS = 12,
	localparam int MAG_W      = dpbp_pkg::mag_width(COORD_BITS),
	localparam int ENT_W      = dpbp_pkg::entry_width(COORD_BITS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	dpbp_pixel_if.sink             pixel,
	input  wire dpbp_pkg::cfg_t    regs,
	input  wire logic              full,
	output logic                   push,
	output logic [ENT_W-1:0]       push_data
);

	localparam int CMP_W = (COORD_BITS + 1 > dpbp_pkg::WIDTH_W) ? COORD_BITS + 1
		: dpbp_pkg::WIDTH_W;

	typedef struct packed {
		logic                             pv;
		logic                             neg_x;
		logic [MAG_W-1:0]                 mag_x;
		logic                             neg_y;
		logic [MAG_W-1:0]                 mag_y;
		logic [dpbp_pkg::DEPTH_W-1:0]     depth;
		logic [dpbp_pkg::COLOR_W-1:0]     blue;
		logic [dpbp_pkg::COLOR_W-1:0]     green;
		logic [dpbp_pkg::COLOR_W-1:0]     red;
	} entry_t;

	logic [COORD_BITS-1:0] col_q, row_q;
	logic [COORD_BITS-1:0] col, row;
	logic [COORD_BITS:0]   next_col;
	logic                  wrap, keep, in_range, take;
	logic [MAG_W-1:0]      p16x, p16y, cx, cy;
	entry_t                ent;

	// Start of frame puts this pixel at the origin.
	always_comb begin
		col = pixel.start_of_frame ? '0 : col_q;
		row = pixel.start_of_frame ? '0 : row_q;
	end

	// Column wrap at the image width or at counter overflow.
	assign next_col = {1'b0, col} + (COORD_BITS+1)'(1);
	assign wrap     = (CMP_W'(next_col) >= CMP_W'(regs.image_width)) || next_col[COORD_BITS];

	// Classification of the pixel.
	assign keep     = !regs.decimate || !(col[0] || row[0]);
	assign in_range = (pixel.depth_mm != '0) && (pixel.depth_mm <= regs.depth_limit);

	// Signed offsets from the principal point, split into sign and magnitude.
	assign p16x = MAG_W'({col, 4'b0000});
	assign p16y = MAG_W'({row, 4'b0000});
	assign cx   = MAG_W'(regs.center_x);
	assign cy   = MAG_W'(regs.center_y);

	always_comb begin
		ent = '0;
		if (in_range) begin
			ent.pv    = 1'b1;
			ent.neg_x = p16x < cx;
			ent.mag_x = (p16x < cx) ? (cx - p16x) : (p16x - cx);
			ent.neg_y = p16y < cy;
			ent.mag_y = (p16y < cy) ? (cy - p16y) : (p16y - cy);
			ent.depth = pixel.depth_mm;
			ent.blue  = pixel.blue;
			ent.green = pixel.green;
			ent.red   = pixel.red;
		end
	end

	// Handshake: a pixel is taken whenever the queue has room.
	assign pixel.ready = !full;
	assign take        = pixel.valid && !full;
	assign push        = take && keep;
	assign push_data   = ent;

	// Column and row counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= row + COORD_BITS'(1);
			end else begin
				col_q <= next_col[COORD_BITS-1:0];
				row_q <= row;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/dpbp_fifo.sv]
// Small first-word-fall-through queue between the front and back ends.
// Depends on nothing but its parameters.
`default_nettype none

module dpbp_fifo #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic                  full,
	output logic                  empty,
	output logic [WIDTH-1:0]      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/dpbp_back.sv]
// Back end: a four-stage multiply, round and saturate pipeline that turns
// queue entries into points. Depends on dpbp_pkg and dpbp_point_if.
`default_nettype none

module dpbp_back #(
	parameter  int COORD_BITS = 12,
	localparam int MAG_W      = dpbp_pkg::mag_width(COORD_BITS),
	localparam int ENT_W      = dpbp_pkg::entry_width(COORD_BITS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dpbp_pkg::cfg_t    regs,
	input  wire logic              empty,
	input  wire logic [ENT_W-1:0]  head,
	output logic                   pop,
	dpbp_point_if.source           point
);

	localparam int DW    = dpbp_pkg::DEPTH_W;
	localparam int P1_W  = MAG_W + dpbp_pkg::INV_W;
	localparam int LO_W  = 22;
	localparam int HI_W  = P1_W - LO_W;
	localparam int PL_W  = LO_W + DW + 1;
	localparam int PH_W  = HI_W + DW;
	localparam int SUM_W = P1_W + DW + 1;
	localparam int R_W   = SUM_W - 24;
	localparam int XW    = dpbp_pkg::XY_W;

	typedef struct packed {
		logic                             pv;
		logic                             neg_x;
		logic [MAG_W-1:0]                 mag_x;
		logic                             neg_y;
		logic [MAG_W-1:0]                 mag_y;
		logic [DW-1:0]                    depth;
		logic [dpbp_pkg::COLOR_W-1:0]     blue;
		logic [dpbp_pkg::COLOR_W-1:0]     green;
		logic [dpbp_pkg::COLOR_W-1:0]     red;
	} entry_t;

	// Fields that ride along with the products.
	typedef struct packed {
		logic                             pv;
		logic                             neg_x;
		logic                             neg_y;
		logic [DW-1:0]                    depth;
		logic [dpbp_pkg::COLOR_W-1:0]     blue;
		logic [dpbp_pkg::COLOR_W-1:0]     green;
		logic [dpbp_pkg::COLOR_W-1:0]     red;
	} meta_t;

	entry_t                ent;
	logic                  en;
	logic                  v_s1, v_s2, v_s3, v_s4;
	meta_t                 meta_s1, meta_s2, meta_s3;
	logic [P1_W-1:0]       px_s1, py_s1;
	logic [PL_W-1:0]       lx_s2, ly_s2;
	logic [PH_W-1:0]       hx_s2, hy_s2;
	logic [SUM_W-1:0]      sum_x, sum_y;
	logic [R_W-1:0]        rx_s3, ry_s3;
	logic                  pv_s4;
	logic signed [XW-1:0]  x_s4, y_s4, x_sat, y_sat;
	logic [DW-1:0]         z_s4;
	logic [dpbp_pkg::COLOR_W-1:0] b_s4, g_s4, r_s4;

	// Saturate a rounded magnitude to signed 32 bits after applying its sign.
	function automatic logic [XW-1:0] saturate(input logic neg, input logic [R_W-1:0] r);
		logic over;
		over = |r[R_W-1:XW-1];
		if (neg) begin
			return over ? {1'b1, {(XW-1){1'b0}}} : (XW)'(0) - r[XW-1:0];
		end else begin
			return over ? {1'b0, {(XW-1){1'b1}}} : r[XW-1:0];
		end
	endfunction

	// The whole pipeline moves when the output register is free or taken.
	assign ent = head;
	assign en  = !v_s4 || point.ready;
	assign pop = en && !empty;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= !empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: offset magnitude times inverse focal length.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= P1_W'(ent.mag_x) * P1_W'(regs.inv_focal_x);
			py_s1   <= P1_W'(ent.mag_y) * P1_W'(regs.inv_focal_y);
			meta_s1 <= '{pv: ent.pv, neg_x: ent.neg_x, neg_y: ent.neg_y, depth: ent.depth,
				blue: ent.blue, green: ent.green, red: ent.red};
		end
	end

	// Stage 2: partial products with depth; the rounding half goes in the low part.
	always_ff @(posedge clk) begin
		if (en) begin
			lx_s2   <= PL_W'(px_s1[LO_W-1:0]) * PL_W'(meta_s1.depth) + PL_W'(24'h80_0000);
			ly_s2   <= PL_W'(py_s1[LO_W-1:0]) * PL_W'(meta_s1.depth) + PL_W'(24'h80_0000);
			hx_s2   <= PH_W'(px_s1[P1_W-1:LO_W]) * PH_W'(meta_s1.depth);
			hy_s2   <= PH_W'(py_s1[P1_W-1:LO_W]) * PH_W'(meta_s1.depth);
			meta_s2 <= meta_s1;
		end
	end

	// Stage 3: combine the partial products and drop the fraction bits.
	assign sum_x = (SUM_W'(hx_s2) << LO_W) + SUM_W'(lx_s2);
	assign sum_y = (SUM_W'(hy_s2) << LO_W) + SUM_W'(ly_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s3   <= sum_x[SUM_W-1:24];
			ry_s3   <= sum_y[SUM_W-1:24];
			meta_s3 <= meta_s2;
		end
	end

	// Stage 4: sign, saturation and the output register.
	assign x_sat = saturate(meta_s3.neg_x, rx_s3);
	assign y_sat = saturate(meta_s3.neg_y, ry_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			pv_s4 <= meta_s3.pv;
			x_s4  <= meta_s3.pv ? x_sat : '0;
			y_s4  <= meta_s3.pv ? y_sat : '0;
			z_s4  <= meta_s3.depth;
			b_s4  <= meta_s3.blue;
			g_s4  <= meta_s3.green;
			r_s4  <= meta_s3.red;
		end
	end

	assign point.valid       = v_s4;
	assign point.point_valid = pv_s4;
	assign point.x_pos       = x_s4;
	assign point.y_pos       = y_s4;
	assign point.z_pos       = z_s4;
	assign point.blue_out    = b_s4;
	assign point.green_out   = g_s4;
	assign point.red_out     = r_s4;

endmodule

`default_nettype wire

[hw/rtl/depth_pixel_back_projection_top.sv]
// Top level of the depth pixel back-projection block: configuration
// registers, front end, entry queue and back-end pipeline. Depends on dpbp_pkg,
// dpbp_ifs, dpbp_regs, dpbp_front, dpbp_fifo and dpbp_back.
//
// The block takes one raster pixel per clock and gives one point per kept
// pixel, sustaining one item per cycle while the point sink keeps up. A pixel
// is written into a four-entry queue when it is accepted, then leaves the
// queue into the first of the four back-end stages (two multiply stages,
// the sum of the partial products and the saturation) and moves through
// them to the output register. The queue lets the pixel side keep flowing
// for up to four items while the point side stalls. Column and row are
// counted here; a start-of-frame pixel is column zero, row zero.
// Configuration must be written while no pixel is in flight; the block
// itself does not enforce this.
`default_nettype none

module depth_pixel_back_projection_top #(
	parameter int COORD_BITS = 12
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	dpbp_pixel_if.sink     pixel,
	dpbp_point_if.source   point,
	dpbp_cfg_if.sink       cfg
);

	localparam int ENT_W = dpbp_pkg::entry_width(COORD_BITS);

	dpbp_pkg::cfg_t   regs;
	logic             push, pop, full, empty;
	logic [ENT_W-1:0] push_data, head;

	// Configuration registers.
	dpbp_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Pixel intake and classification.
	dpbp_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.regs      (regs),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// Queue between front and back.
	dpbp_fifo #(.WIDTH(ENT_W), .DEPTH(4)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head      (head)
	);

	// Projection pipeline.
	dpbp_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.point  (point)
	);

endmodule

`default_nettype wire

[hw/rtl/dpbp_checker.sv]
// Port-level checks for the depth pixel back-projection top level, with the
// bind that attaches them. Depends on dpbp_pkg for field widths.
`default_nettype none

module dpbp_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               cfg_ready,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic                               point_valid,
	input wire logic [dpbp_pkg::XY_W-1:0]          x_pos,
	input wire logic [dpbp_pkg::XY_W-1:0]          y_pos,
	input wire logic [dpbp_pkg::DEPTH_W-1:0]       z_pos,
	input wire logic [dpbp_pkg::COLOR_W-1:0]       blue_out,
	input wire logic [dpbp_pkg::COLOR_W-1:0]       green_out,
	input wire logic [dpbp_pkg::COLOR_W-1:0]       red_out
);

	// A stalled point holds its valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("point valid dropped while stalled");

	// An invalid point carries only zero fields.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> x_pos == '0 && y_pos == '0 && z_pos == '0
			&& blue_out == '0 && green_out == '0 && red_out == '0)
		else $error("invalid point with nonzero fields");

	// A valid point always has a measured depth.
	a_valid_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && point_valid |-> z_pos != '0)
		else $error("valid point with zero depth");

	// Configuration writes are never refused once out of reset.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind depth_pixel_back_projection_top dpbp_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_ready   (cfg.ready),
	.out_valid   (point.valid),
	.out_ready   (point.ready),
	.point_valid (point.point_valid),
	.x_pos       (point.x_pos),
	.y_pos       (point.y_pos),
	.z_pos       (point.z_pos),
	.blue_out    (point.blue_out),
	.green_out   (point.green_out),
	.red_out     (point.red_out)
);

`default_nettype wire

[sim/dpbp_point_scoreboard.sv]
`timescale 1ns / 1ps
// Scoreboard for the depth pixel back-projection testbench: pixel and point
// item types and a class that predicts and checks points. Depends on dpbp_pkg.

package dpbp_tb_pkg;
	import dpbp_pkg::*;

	// Counter width the block is built with in this bench.
	localparam int TB_COORD_BITS = 12;

	// Index outside the register map; writes to it must change nothing.
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

	// One pixel item as driven on the input channel.
	typedef struct packed {
		logic [DEPTH_W-1:0] depth_mm;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
		logic               start_of_frame;
	} pixel_t;

	// One point item as seen on the output channel.
	typedef struct packed {
		logic                     point_valid;
		logic signed [XY_W-1:0]   x_pos;
		logic signed [XY_W-1:0]   y_pos;
		logic [DEPTH_W-1:0]       z_pos;
		logic [COLOR_W-1:0]       blue_out;
		logic [COLOR_W-1:0]       green_out;
		logic [COLOR_W-1:0]       red_out;
	} point_t;

	class point_scoreboard;
		cfg_t                     regs;
		logic [TB_COORD_BITS-1:0] col;
		logic [TB_COORD_BITS-1:0] row;
		point_t                   expected_points[$];
		int                       mismatches;

		function new();
			regs.image_width = RST_IMAGE_WIDTH;
			regs.center_x    = RST_CENTER_X;
			regs.center_y    = RST_CENTER_Y;
			regs.inv_focal_x = RST_INV_FOCAL_X;
			regs.inv_focal_y = RST_INV_FOCAL_Y;
			regs.depth_limit = RST_DEPTH_LIMIT;
			regs.decimate    = RST_DECIMATE;
			col = '0;
			row = '0;
			mismatches = 0;
		endfunction

		// Mirror a register write; unknown indexes are ignored.
		function void set_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
			case (idx)
				REG_IMAGE_WIDTH: regs.image_width = value[WIDTH_W-1:0];
				REG_CENTER_X:    regs.center_x    = value[CTR_W-1:0];
				REG_CENTER_Y:    regs.center_y    = value[CTR_W-1:0];
				REG_INV_FOCAL_X: regs.inv_focal_x = value[INV_W-1:0];
				REG_INV_FOCAL_Y: regs.inv_focal_y = value[INV_W-1:0];
				REG_DEPTH_LIMIT: regs.depth_limit = value[DEPTH_W-1:0];
				REG_DECIMATE:    regs.decimate    = value[0];
				default: ;
			endcase
		endfunction

		// Offset (pos*16 - centre) times 1/f times depth, scaled by 2^-24 with
		// rounding half away from zero, then saturated to 32 signed bits.
		function logic signed [XY_W-1:0] offset_to_mm16(input logic [TB_COORD_BITS-1:0] pos,
				input logic [CTR_W-1:0] centre, input logic [INV_W-1:0] inv,
				input logic [DEPTH_W-1:0] z);
			logic [63:0] p16;
			logic [63:0] c;
			logic [63:0] mag;
			logic [63:0] prod;
			logic [63:0] r;
			logic        neg;
			p16  = 64'(pos) << 4;
			c    = 64'(centre);
			neg  = p16 < c;
			mag  = neg ? c - p16 : p16 - c;
			prod = mag * 64'(inv) * 64'(z);
			r    = (prod + 64'h80_0000) >> 24;
			if (neg)
				return (r >= 64'h8000_0000) ? 32'h8000_0000 : -r[31:0];
			return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
		endfunction

		// Advance the raster position for an accepted pixel and queue its point.
		function void note_pixel(input pixel_t px);
			point_t pt;
			if (px.start_of_frame) begin
				col = '0;
				row = '0;
			end
			if (!regs.decimate || !(col[0] | row[0])) begin
				pt = '0;
				if (px.depth_mm != 0 && px.depth_mm <= regs.depth_limit) begin
					pt.point_valid = 1'b1;
					pt.x_pos = offset_to_mm16(col, regs.center_x, regs.inv_focal_x, px.depth_mm);
					pt.y_pos = offset_to_mm16(row, regs.center_y, regs.inv_focal_y, px.depth_mm);
					pt.z_pos     = px.depth_mm;
					pt.blue_out  = px.blue;
					pt.green_out = px.green;
					pt.red_out   = px.red;
				end
				expected_points.push_back(pt);
			end
			// A row ends at the programmed width or when the column counter is full.
			if (32'(col) + 1 >= 32'(regs.image_width) || col == '1) begin
				col = '0;
				row = row + 1'b1;
			end else begin
				col = col + 1'b1;
			end
		endfunction

		// Compare an output point with the oldest expected one.
		function void check_point(input point_t got);
			point_t want;
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: point with none expected: valid=%0d x=%0d y=%0d z=%0d",
						got.point_valid, got.x_pos, got.y_pos, got.z_pos);
				return;
			end
			want = expected_points.pop_front();
			if (got.point_valid !== want.point_valid || got.x_pos !== want.x_pos ||
					got.y_pos !== want.y_pos || got.z_pos !== want.z_pos ||
					got.blue_out !== want.blue_out || got.green_out !== want.green_out ||
					got.red_out !== want.red_out) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: point mismatch at %0t", $realtime);
					$display("  expected valid=%0d x=%0d y=%0d z=%0d bgr=%0d/%0d/%0d",
						want.point_valid, want.x_pos, want.y_pos, want.z_pos,
						want.blue_out, want.green_out, want.red_out);
					$display("  actual   valid=%0d x=%0d y=%0d z=%0d bgr=%0d/%0d/%0d",
						got.point_valid, got.x_pos, got.y_pos, got.z_pos,
						got.blue_out, got.green_out, got.red_out);
				end
			end
		endfunction

		function int pending();
			return expected_points.size();
		endfunction
	endclass

endpackage

[sim/depth_pixel_back_projection_top_tb.sv]
`timescale 1ns / 1ps
// Testbench for depth_pixel_back_projection_top: drives pixels and register
// writes, checks every point. Depends on dpbp_pkg, dpbp_ifs and dpbp_tb_pkg.

module depth_pixel_back_projection_top_tb;
	import dpbp_pkg::*;
	import dpbp_tb_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 16;

	logic clk;
	logic arst_n;
	bit   bursts_on;
	int   stall_left;

	point_scoreboard sb;

	dpbp_pixel_if pixel_ch ();
	dpbp_point_if point_ch ();
	dpbp_cfg_if   cfg_ch ();

	depth_pixel_back_projection_top #(
		.COORD_BITS(TB_COORD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel_ch),
		.point(point_ch),
		.cfg(cfg_ch)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Give up if the run hangs.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	// Point side: check accepted items and stall in random bursts.
	always @(posedge clk) begin
		if (arst_n && point_ch.valid && point_ch.ready)
			sb.check_point({point_ch.point_valid, point_ch.x_pos, point_ch.y_pos,
				point_ch.z_pos, point_ch.blue_out, point_ch.green_out, point_ch.red_out});
		if (stall_left == 0 && bursts_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 4);
		if (stall_left > 0) begin
			stall_left--;
			point_ch.ready <= 1'b0;
		end else begin
			point_ch.ready <= 1'b1;
		end
	end

	// Offer one pixel, possibly after a short gap, and wait until it is taken.
	task automatic drive_pixel(input logic [DEPTH_W-1:0] depth, input logic [COLOR_W-1:0] b,
			input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r, input logic sof);
		pixel_t px;
		px = {depth, b, g, r, sof};
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			pixel_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		pixel_ch.valid          <= 1'b1;
		pixel_ch.depth_mm       <= px.depth_mm;
		pixel_ch.blue           <= px.blue;
		pixel_ch.green          <= px.green;
		pixel_ch.red            <= px.red;
		pixel_ch.start_of_frame <= px.start_of_frame;
		@(posedge clk);
		while (!pixel_ch.ready) @(posedge clk);
		sb.note_pixel(px);
	endtask

	// Stop offering pixels and wait until every point is out and the pipe is empty.
	task automatic drain();
		pixel_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; valid stays high for a following write.
	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		sb.set_register(idx, value);
	endtask

	// Write every register, plus one write to an unmapped index.
	task automatic load_settings(input cfg_t c);
		write_register(REG_IMAGE_WIDTH, DATA_W'(c.image_width));
		write_register(REG_CENTER_X, DATA_W'(c.center_x));
		write_register(REG_CENTER_Y, DATA_W'(c.center_y));
		write_register(REG_UNUSED, DATA_W'($urandom));
		write_register(REG_INV_FOCAL_X, c.inv_focal_x);
		write_register(REG_INV_FOCAL_Y, c.inv_focal_y);
		write_register(REG_DEPTH_LIMIT, DATA_W'(c.depth_limit));
		write_register(REG_DECIMATE, DATA_W'(c.decimate));
		cfg_ch.valid <= 1'b0;
	endtask

	// Random pixels: mostly valid depths, with zero, over-limit and full-scale
	// depths mixed in and an occasional start of frame.
	task automatic random_pixels(input int count, input bit bursty);
		logic [DEPTH_W-1:0] lim;
		logic [DEPTH_W-1:0] depth;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				bursts_on = bursty && $urandom_range(0, 2) != 0;
			lim = sb.regs.depth_limit;
			case ($urandom_range(0, 9))
				0: depth = '0;
				1: depth = '1;
				2: depth = DEPTH_W'($urandom);
				3: depth = (lim == '1) ? lim : lim + 1'b1;
				4: depth = lim;
				default: depth = (lim == 0) ? DEPTH_W'($urandom) : DEPTH_W'($urandom_range(1, lim));
			endcase
			drive_pixel(depth, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
				$urandom_range(0, 99) == 0);
		end
	endtask

	// Stimulus and final verdict.
	initial begin
		cfg_t s;
		sb = new();
		arst_n = 1'b0;
		bursts_on = 1'b1;
		stall_left = 0;
		pixel_ch.valid = 1'b0;
		pixel_ch.depth_mm = '0;
		pixel_ch.blue = '0;
		pixel_ch.green = '0;
		pixel_ch.red = '0;
		pixel_ch.start_of_frame = 1'b0;
		point_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: limits of depth, color bit patterns, start of frame mid-row.
		drive_pixel(16'd1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		drive_pixel(16'd0, 8'd12, 8'd34, 8'd56, 1'b0);
		drive_pixel(16'd1000, 8'hAA, 8'h55, 8'hAA, 1'b0);
		drive_pixel(16'd1001, 8'h55, 8'hAA, 8'h55, 1'b0);
		drive_pixel(16'hFFFF, 8'hFF, 8'h00, 8'hFF, 1'b0);
		drive_pixel(16'd500, 8'h00, 8'h00, 8'h00, 1'b0);
		drive_pixel(16'h5555, 8'h01, 8'h80, 8'h7F, 1'b0);
		drive_pixel(16'hAAAA, 8'h80, 8'h01, 8'hFE, 1'b0);
		drive_pixel(16'd999, 8'h55, 8'hAA, 8'h55, 1'b1);
		drive_pixel(16'd321, 8'h0F, 8'hF0, 8'h3C, 1'b0);
		drive_pixel(16'd2, 8'hC3, 8'h99, 8'h66, 1'b0);
		drain();

		// Extreme settings with decimation: saturation toward negative x, dropped pixels.
		s = '{image_width: 13'd3, center_x: 16'hFFFF, center_y: 16'h0000,
			inv_focal_x: 24'hFF_FFFF, inv_focal_y: 24'hFF_FFFF, depth_limit: 16'hFFFF,
			decimate: 1'b1};
		load_settings(s);
		drive_pixel(16'hFFFF, 8'h11, 8'h22, 8'h33, 1'b1);
		drive_pixel(16'hFFFF, 8'h44, 8'h55, 8'h66, 1'b0);
		drive_pixel(16'd777, 8'h77, 8'h88, 8'h99, 1'b0);
		drive_pixel(16'd40000, 8'hAA, 8'hBB, 8'hCC, 1'b0);
		drive_pixel(16'd1, 8'hDD, 8'hEE, 8'hFF, 1'b0);
		drive_pixel(16'd0, 8'h12, 8'h34, 8'h56, 1'b0);
		drive_pixel(16'd65534, 8'h9A, 8'hBC, 8'hDE, 1'b0);
		drive_pixel(16'd3, 8'hF0, 8'h0F, 8'h5A, 1'b0);
		drive_pixel(16'hFFFF, 8'hA5, 8'h5A, 8'hC3, 1'b1);
		drain();

		// Random phases, each under its own settings.
		for (int ph = 0; ph < 6; ph++) begin
			s.image_width = WIDTH_W'($urandom_range(1, 4096));
			s.center_x    = CTR_W'($urandom);
			s.center_y    = CTR_W'($urandom);
			s.inv_focal_x = INV_W'($urandom);
			s.inv_focal_y = INV_W'($urandom);
			s.depth_limit = DEPTH_W'($urandom);
			s.decimate    = 1'($urandom);
			case (ph)
				0: begin
					// Zero width ends every row; a zero limit rejects every depth.
					s.image_width = '0;
					s.depth_limit = '0;
					s.decimate = 1'b0;
				end
				1: begin
					s.image_width = 13'd1;
					s.decimate = 1'b1;
				end
				2: begin
					s.image_width = WIDTH_W'($urandom_range(2, 40));
					s.depth_limit = '1;
					s.decimate = 1'b0;
				end
				3: begin
					s.image_width = 13'd4096;
					s.inv_focal_x = '0;
					s.decimate = 1'b1;
				end
				4: begin
					s.image_width = 13'd7;
					s.center_x = '0;
					s.decimate = 1'b1;
				end
				default: begin
					// Widest register value with full-scale x focal and depth settings.
					s.image_width = '1;
					s.center_x = '0;
					s.center_y = '1;
					s.inv_focal_x = '1;
					s.depth_limit = '1;
					s.decimate = 1'b0;
				end
			endcase
			load_settings(s);
			if (ph < 5)
				random_pixels(200, 1'b1);
			else
				random_pixels(230, 1'b0);
			drain();
		end

		bursts_on = 1'b0;
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
